@@ rtl/grt_pkg.sv @@
// Shared types and constants for the gamepad report translator.
// No dependencies.
`timescale 1ns / 1ps

package grt_pkg;

   localparam int unsigned AxisFull = 32767;

   typedef enum logic [1:0] {
      CSR_TRIG_LEVEL     = 2'd0,
      CSR_LEFT_DEADZONE  = 2'd1,
      CSR_RIGHT_DEADZONE = 2'd2,
      CSR_HB_PERIOD      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_PREP   = 2'd1,
      BK_DIVIDE = 2'd2,
      BK_FINISH = 2'd3
   } back_state_type;

   localparam logic [3:0] HatNone = 4'd8;

   // One classified sample as it travels from front to back.
   typedef struct packed {
      logic        connected;
      logic [15:0] buttons;
      logic [7:0]  trig_l;
      logic [7:0]  trig_r;
      logic [15:0] axis_lx;
      logic [15:0] axis_ly;
      logic [15:0] axis_rx;
      logic [15:0] axis_ry;
   } sample_type;

   // Normalized state, as compared and stored.
   typedef struct packed {
      logic        connected;
      logic [15:0] buttons;
      logic [7:0]  trig_l;
      logic [7:0]  trig_r;
      logic [8:0]  ax0;
      logic [8:0]  ax1;
      logic [8:0]  ax2;
      logic [8:0]  ax3;
   } norm_type;

   typedef struct packed {
      logic        connected;
      logic [17:0] buttons;
      logic [3:0]  hat;
      logic [7:0]  lx;
      logic [7:0]  ly;
      logic [7:0]  rx;
      logic [7:0]  ry;
      logic        neutral;
      logic        heartbeat;
   } report_type;

   function automatic logic [3:0] hat_of(input logic [15:0] b);
      logic [3:0] h;
      case ({b[0], b[1], b[2], b[3]}) // up, down, left, right
         4'b1000, 4'b1011: h = 4'd0;
         4'b1001:          h = 4'd1;
         4'b0001, 4'b1101: h = 4'd2;
         4'b0101:          h = 4'd3;
         4'b0100, 4'b0111: h = 4'd4;
         4'b0110:          h = 4'd5;
         4'b0010, 4'b1110: h = 4'd6;
         4'b1010:          h = 4'd7;
         default:          h = HatNone;
      endcase
      return h;
   endfunction

   // Axis plus 128 clamped to a byte.
   function automatic logic [7:0] to_byte(input logic [8:0] a);
      logic [9:0] v;
      v = {a[8], a} + 10'd128;
      return (v[9:8] == 2'b01) ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [8:0] negate(input logic [8:0] a);
      return 9'd0 - a;
   endfunction

endpackage

@@ rtl/grt_front.sv @@
// Front end: input queue interface, masks disconnected samples and buttons.
// Depends on grt_pkg.
`timescale 1ns / 1ps

module grt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                in_connected,
   input  logic [15:0]         in_buttons,
   input  logic [7:0]          in_trig_l,
   input  logic [7:0]          in_trig_r,
   input  logic [15:0]         in_lx,
   input  logic [15:0]         in_ly,
   input  logic [15:0]         in_rx,
   input  logic [15:0]         in_ry,
   output logic                q_valid,
   output grt_pkg::sample_type q_data,
   input  logic                q_take
);

   // Two-entry queue between front and back.
   grt_pkg::sample_type mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       push_ok, take_ok;
   grt_pkg::sample_type s;

   assign req_full = count_ff[1];
   assign push_ok  = req_push && !req_full;
   assign take_ok  = q_take && q_valid;
   assign q_valid  = count_ff != 2'd0;
   assign q_data   = mem_ff[rd_ff];

   always_comb begin
      s = '0;
      if (in_connected) begin
         s.connected = 1'b1;
         s.buttons   = in_buttons & 16'hF3FF;
         s.trig_l    = in_trig_l;
         s.trig_r    = in_trig_r;
         s.axis_lx   = in_lx;
         s.axis_ly   = in_ly;
         s.axis_rx   = in_rx;
         s.axis_ry   = in_ry;
      end
      count_in = count_ff + {1'b0, push_ok} - {1'b0, take_ok};
      wr_in    = wr_ff ^ push_ok;
      rd_in    = rd_ff ^ take_ok;
   end

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ff] <= s;
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push_ok && !take_ok |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not advance");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> !take_ok) else $error("take from empty queue");
`endif

endmodule

@@ rtl/grt_back.sv @@
// Back end: axis scaling with a shared serial divider, change detect,
// heartbeat, and the output register. Depends on grt_pkg.
`timescale 1ns / 1ps

module grt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  grt_pkg::sample_type q_data,
   output logic                q_take,
   input  logic [7:0]          trig_level,
   input  logic [14:0]         left_deadzone,
   input  logic [14:0]         right_deadzone,
   input  logic [7:0]          hb_period,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output grt_pkg::report_type rsp_data
);

   grt_pkg::back_state_type state_ff, state_in;
   logic [1:0]  axis_ff, axis_in;
   logic [4:0]  bit_ff, bit_in;
   // quotient of (256m + D) / 2D, at most 8 bits since m < D
   logic [24:0] rem_ff, rem_in;      // partial remainder on top, dividend bits below
   logic [7:0]  quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;      // 2D
   logic        neg_ff, neg_in;
   logic [8:0]  ax_ff [4];
   logic [8:0]  ax_in;
   logic        ax_we;
   grt_pkg::norm_type prev_ff, prev_in;
   logic [7:0]  cnt_ff, cnt_in;
   grt_pkg::report_type out_ff, out_in;
   logic        full_ff, full_in;
   logic        prev_we;

   logic [15:0] raw;
   logic [14:0] dz;
   logic [15:0] mag, m, d;
   logic [24:0] rem_sh;
   logic [17:0] trial;
   logic [8:0]  r9;
   logic [7:0]  cnt_inc;
   logic        changed;
   grt_pkg::norm_type cur;
   logic        out_done;

   function automatic grt_pkg::report_type report(input grt_pkg::norm_type p,
                                                  input logic hb);
      grt_pkg::report_type o;
      logic [15:0] b;
      b = p.buttons;
      o = '0;
      o.connected = p.connected;
      o.neutral   = (b == 16'd0) && (p.trig_l == 8'd0) && (p.trig_r == 8'd0)
                    && (p.ax0 == 9'd0) && (p.ax1 == 9'd0)
                    && (p.ax2 == 9'd0) && (p.ax3 == 9'd0);
      o.heartbeat = hb;
      o.hat = grt_pkg::HatNone;
      o.lx  = 8'd128;
      o.ly  = 8'd128;
      o.rx  = 8'd128;
      o.ry  = 8'd128;
      if (p.connected) begin
         o.buttons = {b[3], b[2], b[1], b[0], 1'b0, b[5], b[4], b[5], b[7], b[6],
                      p.trig_r >= trig_level, p.trig_l >= trig_level,
                      b[9], b[8], b[15], b[14], b[13], b[12]};
         o.hat = grt_pkg::hat_of(b);
         o.lx  = grt_pkg::to_byte(p.ax0);
         o.ly  = grt_pkg::to_byte(grt_pkg::negate(p.ax1));
         o.rx  = grt_pkg::to_byte(p.ax2);
         o.ry  = grt_pkg::to_byte(grt_pkg::negate(p.ax3));
      end
      return o;
   endfunction

   assign out_done  = rsp_pop && full_ff;
   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      case (axis_ff)
         2'd0:    raw = q_data.axis_lx;
         2'd1:    raw = q_data.axis_ly;
         2'd2:    raw = q_data.axis_rx;
         default: raw = q_data.axis_ry;
      endcase
      dz     = axis_ff[1] ? right_deadzone : left_deadzone;
      mag    = raw[15] ? 16'd0 - raw : raw;   // 32768 stays as 0x8000
      m      = mag - {1'b0, dz};
      d      = 16'(grt_pkg::AxisFull) - {1'b0, dz};
      rem_sh = rem_ff << 1;
      trial  = {1'b0, rem_sh[24:8]} - {2'b0, dvs_ff};
      r9     = {1'b0, quo_ff};
   end

   always_comb begin
      cur.connected = q_data.connected;
      cur.buttons   = q_data.buttons;
      cur.trig_l    = q_data.trig_l;
      cur.trig_r    = q_data.trig_r;
      cur.ax0       = ax_ff[0];
      cur.ax1       = ax_ff[1];
      cur.ax2       = ax_ff[2];
      cur.ax3       = ax_ff[3];
      changed = cur != prev_ff;
      cnt_inc = cnt_ff + 8'd1;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         grt_pkg::BK_IDLE:   if (q_valid) state_in = grt_pkg::BK_PREP;
         grt_pkg::BK_PREP: begin
            if (mag > {1'b0, dz} && m < d) state_in = grt_pkg::BK_DIVIDE;
            else if (axis_ff == 2'd3) state_in = grt_pkg::BK_FINISH;
         end
         grt_pkg::BK_DIVIDE: begin
            if (bit_ff == 5'd0)
               state_in = (axis_ff == 2'd3) ? grt_pkg::BK_FINISH : grt_pkg::BK_PREP;
         end
         grt_pkg::BK_FINISH: if (!full_ff || out_done) state_in = grt_pkg::BK_IDLE;
         default: state_in = grt_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      axis_in = axis_ff;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      ax_we   = 1'b0;
      ax_in   = '0;
      q_take  = 1'b0;
      prev_we = 1'b0;
      prev_in = prev_ff;
      cnt_in  = cnt_ff;
      out_in  = out_ff;
      full_in = full_ff && !out_done;
      case (state_ff)
         grt_pkg::BK_IDLE: axis_in = 2'd0;
         grt_pkg::BK_PREP: begin
            neg_in = raw[15];
            dvs_in = {d[14:0], 1'b0};
            rem_in = {1'b0, m[15:0], 8'd0} + {9'd0, d};
            quo_in = '0;
            bit_in = 5'd8;
            if (!(mag > {1'b0, dz} && m < d)) begin
               ax_we = 1'b1;
               if (mag <= {1'b0, dz}) ax_in = '0;
               else ax_in = raw[15] ? 9'h180 : 9'd128;
               axis_in = axis_ff + 2'd1;
            end
         end
         grt_pkg::BK_DIVIDE: begin
            // restoring division, one quotient bit per cycle
            if (bit_ff == 5'd0) begin
               ax_we   = 1'b1;
               ax_in   = neg_ff ? grt_pkg::negate(r9) : r9;
               axis_in = axis_ff + 2'd1;
            end else begin
               bit_in = bit_ff - 5'd1;
               if (!trial[17]) begin
                  rem_in = {trial[16:0], rem_sh[7:0]};
                  quo_in = {quo_ff[6:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[6:0], 1'b0};
               end
            end
         end
         grt_pkg::BK_FINISH: begin
            if (!full_ff || out_done) begin
               q_take = 1'b1;
               if (changed) begin
                  prev_we = 1'b1;
                  prev_in = cur;
                  cnt_in  = '0;
                  full_in = 1'b1;
                  out_in  = report(cur, 1'b0);
               end else if (cur.connected) begin
                  cnt_in = cnt_inc;
                  if (cnt_inc >= hb_period) begin
                     cnt_in  = '0;
                     full_in = 1'b1;
                     out_in  = report(prev_ff, 1'b1);
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      bit_ff <= bit_in;
      out_ff <= out_in;
      if (ax_we) ax_ff[axis_ff] <= ax_in;
      if (reset) begin
         state_ff <= grt_pkg::BK_IDLE;
         axis_ff  <= '0;
         prev_ff  <= '0;
         cnt_ff   <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         cnt_ff   <= cnt_in;
         full_ff  <= full_in;
         if (prev_we) prev_ff <= prev_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_take_finish: assert property (@(posedge clock) disable iff (reset)
      q_take |-> state_ff == grt_pkg::BK_FINISH && q_valid)
      else $error("take outside finish");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      full_ff && !rsp_pop |=> $stable(out_ff)) else $error("result overwritten");
   a_div_bits: assert property (@(posedge clock) disable iff (reset)
      state_ff == grt_pkg::BK_DIVIDE |-> bit_ff <= 5'd8)
      else $error("divider step count");
`endif

endmodule

@@ rtl/gamepad_report_translator_core.sv @@
// Gamepad report translator top level: config registers, front and back.
// Depends on grt_pkg, grt_front, grt_back.
`timescale 1ns / 1ps

// Usage:
//  Input queue: drive a poll sample on the req_ ports with req_push; it
//  transfers when req_full is low. A two-entry queue holds samples for the
//  back end.
//  Result queue: while rsp_empty is low a report is on the rsp_ ports;
//  pop transfers it. A sample with no change and no heartbeat yields nothing.
//  Each sample passes through the back end in steps: a pickup step, a setup
//  step per stick axis, a run of the shared restoring divider for each axis
//  that lands between dead zone and full scale, and a finish step. The
//  divider sets the rate. A held result stalls the back end only at its
//  finish step; the front keeps taking samples until the queue fills. Reset
//  empties both queues, clears the stored state and heartbeat count and
//  loads the register defaults. Write csr_ registers only while idle.
module gamepad_report_translator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_pad_connected,
   input  logic [15:0] req_button_word,
   input  logic [7:0]  req_left_trigger_raw,
   input  logic [7:0]  req_right_trigger_raw,
   input  logic signed [15:0] req_left_stick_x,
   input  logic signed [15:0] req_left_stick_y,
   input  logic signed [15:0] req_right_stick_x,
   input  logic signed [15:0] req_right_stick_y,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_out_connected,
   output logic [17:0] rsp_out_buttons,
   output logic [3:0]  rsp_hat_direction,
   output logic [7:0]  rsp_out_left_x,
   output logic [7:0]  rsp_out_left_y,
   output logic [7:0]  rsp_out_right_x,
   output logic [7:0]  rsp_out_right_y,
   output logic        rsp_is_neutral,
   output logic        rsp_is_heartbeat,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   logic [7:0]  thr_ff;
   logic [14:0] ldz_ff, rdz_ff;
   logic [7:0]  hb_ff;
   logic        q_valid, q_take;
   grt_pkg::sample_type q_data;
   grt_pkg::report_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 8'd64;
         ldz_ff <= 15'd7849;
         rdz_ff <= 15'd8689;
         hb_ff  <= 8'd25;
      end else if (csr_write) begin
         case (grt_pkg::csr_index_type'(csr_index))
            grt_pkg::CSR_TRIG_LEVEL:     thr_ff <= csr_wdata[7:0];
            grt_pkg::CSR_LEFT_DEADZONE:  ldz_ff <= csr_wdata;
            grt_pkg::CSR_RIGHT_DEADZONE: rdz_ff <= csr_wdata;
            grt_pkg::CSR_HB_PERIOD:      hb_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   grt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .in_connected (req_pad_connected),
      .in_buttons   (req_button_word),
      .in_trig_l    (req_left_trigger_raw),
      .in_trig_r    (req_right_trigger_raw),
      .in_lx        (req_left_stick_x),
      .in_ly        (req_left_stick_y),
      .in_rx        (req_right_stick_x),
      .in_ry        (req_right_stick_y),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_take       (q_take)
   );

   grt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_take         (q_take),
      .trig_level     (thr_ff),
      .left_deadzone  (ldz_ff),
      .right_deadzone (rdz_ff),
      .hb_period      (hb_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp)
   );

   assign rsp_out_connected = rsp.connected;
   assign rsp_out_buttons   = rsp.buttons;
   assign rsp_hat_direction = rsp.hat;
   assign rsp_out_left_x    = rsp.lx;
   assign rsp_out_left_y    = rsp.ly;
   assign rsp_out_right_x   = rsp.rx;
   assign rsp_out_right_y   = rsp.ry;
   assign rsp_is_neutral    = rsp.neutral;
   assign rsp_is_heartbeat  = rsp.heartbeat;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for gamepad_report_translator_core: directed table, then
// random polls across several register settings, with a built-in predictor.
// Depends on grt_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      bit             conn;
      bit [15:0]      btn;
      bit [7:0]       lt;
      bit [7:0]       rt;
      bit signed [15:0] lx;
      bit signed [15:0] ly;
      bit signed [15:0] rx;
      bit signed [15:0] ry;
   } poll_sample_type;

   typedef struct {
      poll_sample_type     smp;
      bit                  known;
      grt_pkg::report_type rep;
   } poll_row_type;

   localparam int CycleLimit = 400000;

   logic        clock, reset;
   logic        req_push, req_full;
   logic        req_pad_connected;
   logic [15:0] req_button_word;
   logic [7:0]  req_left_trigger_raw, req_right_trigger_raw;
   logic signed [15:0] req_left_stick_x, req_left_stick_y;
   logic signed [15:0] req_right_stick_x, req_right_stick_y;
   logic        rsp_empty, rsp_pop;
   logic        rsp_out_connected;
   logic [17:0] rsp_out_buttons;
   logic [3:0]  rsp_hat_direction;
   logic [7:0]  rsp_out_left_x, rsp_out_left_y, rsp_out_right_x, rsp_out_right_y;
   logic        rsp_is_neutral, rsp_is_heartbeat;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [14:0] csr_wdata;

   gamepad_report_translator_core DUT (.*);

   // predictor state and register copy
   int unsigned thr_reg, ldz_reg, rdz_reg, hb_reg;
   bit          st_conn;
   bit [15:0]   st_btn;
   int unsigned st_trig [2];
   int          st_axis [4];
   int unsigned st_count;

   grt_pkg::report_type pending_reports [$];
   int          errors, sent_count, report_count, heartbeat_count, cycles;
   int          send_idle, recv_idle;
   bit          held_once;
   poll_sample_type last_poll;
   poll_row_type    dir_rows [24];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout at %0t, %0d reports still expected", $time,
                  pending_reports.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int scaled_axis(int v, int unsigned dz);
      int mag, m, d;
      mag = (v < 0) ? -v : v;
      if (mag <= int'(dz)) return 0;
      m = mag - int'(dz);
      d = 32767 - int'(dz);
      if (m >= d) return (v < 0) ? -128 : 128;
      m = (256 * m + d) / (2 * d);
      return (v < 0) ? -m : m;
   endfunction

   function automatic bit [7:0] axis_byte(int a);
      int v;
      v = a + 128;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic bit [3:0] hat_code(bit [15:0] b);
      int dx, dy;
      dx = int'(b[3]) - int'(b[2]);
      dy = int'(b[1]) - int'(b[0]);
      if (dx == 0 && dy == 0) return 4'd8;
      if (dx == 0) return (dy > 0) ? 4'd4 : 4'd0;
      if (dy == 0) return (dx > 0) ? 4'd2 : 4'd6;
      if (dx > 0) return (dy > 0) ? 4'd3 : 4'd1;
      return (dy > 0) ? 4'd5 : 4'd7;
   endfunction

   function automatic grt_pkg::report_type build_report(bit hb);
      grt_pkg::report_type r;
      bit [15:0] b;
      b = st_btn;
      r = '0;
      r.connected = st_conn;
      r.hat = 4'd8;
      r.lx = 8'd128; r.ly = 8'd128; r.rx = 8'd128; r.ry = 8'd128;
      if (st_conn) begin
         r.buttons[0]  = b[12];
         r.buttons[1]  = b[13];
         r.buttons[2]  = b[14];
         r.buttons[3]  = b[15];
         r.buttons[4]  = b[8];
         r.buttons[5]  = b[9];
         r.buttons[6]  = st_trig[0] >= thr_reg;
         r.buttons[7]  = st_trig[1] >= thr_reg;
         r.buttons[8]  = b[6];
         r.buttons[9]  = b[7];
         r.buttons[10] = b[5];
         r.buttons[11] = b[4];
         r.buttons[12] = b[5];
         r.buttons[14] = b[0];
         r.buttons[15] = b[1];
         r.buttons[16] = b[2];
         r.buttons[17] = b[3];
         r.hat = hat_code(b);
         r.lx = axis_byte(st_axis[0]);
         r.ly = axis_byte(-st_axis[1]);
         r.rx = axis_byte(st_axis[2]);
         r.ry = axis_byte(-st_axis[3]);
      end
      r.neutral = (b == 0) && st_trig[0] == 0 && st_trig[1] == 0 && st_axis[0] == 0 &&
                  st_axis[1] == 0 && st_axis[2] == 0 && st_axis[3] == 0;
      r.heartbeat = hb;
      return r;
   endfunction

   // Advance the predictor by one poll; returns 1 when a report is due.
   function automatic bit translate_poll(poll_sample_type s,
                                         output grt_pkg::report_type r);
      bit [15:0]   b;
      int unsigned t0, t1;
      int          ax [4];
      b = 0; t0 = 0; t1 = 0;
      ax = '{0, 0, 0, 0};
      if (s.conn) begin
         b = s.btn & 16'hF3FF;
         t0 = s.lt; t1 = s.rt;
         ax[0] = scaled_axis(s.lx, ldz_reg);
         ax[1] = scaled_axis(s.ly, ldz_reg);
         ax[2] = scaled_axis(s.rx, rdz_reg);
         ax[3] = scaled_axis(s.ry, rdz_reg);
      end
      if (s.conn != st_conn || b != st_btn || t0 != st_trig[0] || t1 != st_trig[1] ||
          ax != st_axis) begin
         st_conn = s.conn; st_btn = b;
         st_trig[0] = t0; st_trig[1] = t1;
         st_axis = ax;
         st_count = 0;
         r = build_report(1'b0);
         return 1'b1;
      end
      if (s.conn) begin
         st_count = (st_count + 1) & 8'hFF;
         if (st_count >= hb_reg) begin
            st_count = 0;
            r = build_report(1'b1);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic csr_put(grt_pkg::csr_index_type idx, logic [14:0] v);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         grt_pkg::CSR_TRIG_LEVEL:     thr_reg = v[7:0];
         grt_pkg::CSR_LEFT_DEADZONE:  ldz_reg = v;
         grt_pkg::CSR_RIGHT_DEADZONE: rdz_reg = v;
         grt_pkg::CSR_HB_PERIOD:      hb_reg = v[7:0];
         default: ;
      endcase
   endtask

   // Drive one poll and hold it until it transfers; called at a falling edge.
   task automatic push_poll(poll_sample_type s, bit known, grt_pkg::report_type kr);
      grt_pkg::report_type r;
      while ($urandom_range(0, 99) < send_idle) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_pad_connected = s.conn;
      req_button_word = s.btn;
      req_left_trigger_raw = s.lt;
      req_right_trigger_raw = s.rt;
      req_left_stick_x = s.lx;
      req_left_stick_y = s.ly;
      req_right_stick_x = s.rx;
      req_right_stick_y = s.ry;
      req_push = 1'b1;
      do @(posedge clock); while (req_full);
      sent_count++;
      if (translate_poll(s, r))
         pending_reports.insert(pending_reports.size(), known ? kr : r);
      @(negedge clock);
   endtask

   task automatic drain_reports();
      req_push = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      // polls that yield nothing may still be in the back end
      repeat (150) @(negedge clock);
   endtask

   function automatic bit signed [15:0] pick_axis(int unsigned dz);
      int v;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 65535) - 32768;
         1: v = 0;
         2: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
         3: v = dz + $urandom_range(0, 2) - 1;
         4: v = $urandom_range(0, dz);
         default: v = $urandom_range(dz, 32767);
      endcase
      if (v > 32767) v = 32767;
      if ($urandom_range(0, 1) != 0) v = -v - $urandom_range(0, 1);
      return v[15:0];
   endfunction

   function automatic poll_sample_type random_poll();
      poll_sample_type s;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick >= 10 && pick < 50 && last_poll.conn) return last_poll;
      s.conn = (pick >= 10);
      s.btn = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'(16'd1 << $urandom_range(0, 15));
      if ($urandom_range(0, 2) == 0) s.btn = 0;
      s.lt = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                         : 8'(thr_reg - $urandom_range(0, 1));
      s.rt = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                         : 8'(thr_reg - $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
         s.lt = 0; s.rt = 0;
      end
      s.lx = pick_axis(ldz_reg);
      s.ly = pick_axis(ldz_reg);
      s.rx = pick_axis(rdz_reg);
      s.ry = pick_axis(rdz_reg);
      return s;
   endfunction

   task automatic chk(string name, int e, int a);
      if (e != a) begin
         errors++;
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
      end
   endtask

   always @(posedge clock) begin
      grt_pkg::report_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_reports.size() == 0) begin
            errors++;
            $display("%0t unexpected report, buttons %0h", $time, rsp_out_buttons);
         end else begin
            e = pending_reports.pop_front();
            report_count++;
            if (e.heartbeat) heartbeat_count++;
            chk("connected", e.connected, rsp_out_connected);
            chk("buttons", e.buttons, rsp_out_buttons);
            chk("hat", e.hat, rsp_hat_direction);
            chk("left_x", e.lx, rsp_out_left_x);
            chk("left_y", e.ly, rsp_out_left_y);
            chk("right_x", e.rx, rsp_out_right_x);
            chk("right_y", e.ry, rsp_out_right_y);
            chk("neutral", e.neutral, rsp_is_neutral);
            chk("heartbeat", e.heartbeat, rsp_is_heartbeat);
         end
      end
   end

   // Receiver: random pops, plus one long hold so the input queue backs up.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && sent_count >= 250) begin
            held_once = 1'b1;
            rsp_pop = 1'b0;
            repeat (400) @(negedge clock);
         end
         rsp_pop = ($urandom_range(0, 99) >= recv_idle);
      end
   end

   initial begin
      poll_sample_type s;
      grt_pkg::report_type none;
      int phase, mode;
      none = '0;
      errors = 0; sent_count = 0; report_count = 0; heartbeat_count = 0; cycles = 0;
      held_once = 1'b0;
      send_idle = 10; recv_idle = 72;
      reset = 1'b1;
      req_push = 1'b0;
      req_pad_connected = 1'b0; req_button_word = '0;
      req_left_trigger_raw = '0; req_right_trigger_raw = '0;
      req_left_stick_x = '0; req_left_stick_y = '0;
      req_right_stick_x = '0; req_right_stick_y = '0;
      csr_write = 1'b0; csr_index = grt_pkg::CSR_TRIG_LEVEL; csr_wdata = '0;
      thr_reg = 64; ldz_reg = 7849; rdz_reg = 8689; hb_reg = 25;
      st_conn = 0; st_btn = 0; st_trig = '{0, 0}; st_axis = '{0, 0, 0, 0}; st_count = 0;
      last_poll = '{default: 0};

      // directed rows: known reports where they follow straight from the mapping
      dir_rows[0]  = '{'{1, 0, 0, 0, 0, 0, 0, 0}, 1, '{1, 0, 8, 128, 128, 128, 128, 1, 0}};
      dir_rows[1]  = '{'{0, 16'hFFFF, 255, 255, -32768, -32768, -32768, -32768}, 1,
                       '{0, 0, 8, 128, 128, 128, 128, 1, 0}};
      dir_rows[2]  = '{'{0, 0, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[3]  = '{'{1, 0, 0, 0, 32767, 32767, 32767, 32767}, 1,
                       '{1, 0, 8, 255, 0, 255, 0, 0, 0}};
      dir_rows[4]  = '{'{1, 0, 0, 0, -32768, -32768, -32768, -32768}, 1,
                       '{1, 0, 8, 0, 255, 0, 255, 0, 0}};
      dir_rows[5]  = '{'{1, 16'hFFFF, 255, 255, 0, 0, 0, 0}, 1,
                       '{1, 18'h3DFFF, 8, 128, 128, 128, 128, 0, 0}};
      dir_rows[6]  = '{'{1, 16'h0C00, 0, 0, 0, 0, 0, 0}, 1,
                       '{1, 0, 8, 128, 128, 128, 128, 1, 0}};
      dir_rows[7]  = '{'{1, 16'h0C00, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[8]  = '{'{1, 16'h0001, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[9]  = '{'{1, 16'h0009, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[10] = '{'{1, 16'h0008, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[11] = '{'{1, 16'h000A, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[12] = '{'{1, 16'h0002, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[13] = '{'{1, 16'h0006, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[14] = '{'{1, 16'h0004, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[15] = '{'{1, 16'h0005, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[16] = '{'{1, 16'h0010, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[17] = '{'{1, 16'h0020, 0, 0, 0, 0, 0, 0}, 0, none};
      dir_rows[18] = '{'{1, 0, 63, 64, 0, 0, 0, 0}, 0, none};
      dir_rows[19] = '{'{1, 0, 64, 63, 0, 0, 0, 0}, 0, none};
      dir_rows[20] = '{'{1, 0, 0, 0, 7849, -7849, 8689, -8689}, 0, none};
      dir_rows[21] = '{'{1, 0, 0, 0, 7850, -7850, 8690, -8690}, 0, none};
      dir_rows[22] = '{'{1, 0, 1, 2, 16000, -20000, 30000, -9000}, 0, none};
      dir_rows[23] = '{'{1, 16'hF3C0, 0, 0, 0, 0, 0, 0}, 0, none};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) push_poll(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].rep);
      drain_reports();

      for (phase = 1; phase <= 6; phase++) begin
         case (phase)
            1: begin
               csr_put(grt_pkg::CSR_TRIG_LEVEL, 15'd0);
               csr_put(grt_pkg::CSR_LEFT_DEADZONE, 15'd0);
               csr_put(grt_pkg::CSR_RIGHT_DEADZONE, 15'd0);
               csr_put(grt_pkg::CSR_HB_PERIOD, 15'd1);
            end
            2: begin
               csr_put(grt_pkg::CSR_TRIG_LEVEL, 15'd255);
               csr_put(grt_pkg::CSR_LEFT_DEADZONE, 15'd32767);
               csr_put(grt_pkg::CSR_RIGHT_DEADZONE, 15'd32767);
               csr_put(grt_pkg::CSR_HB_PERIOD, 15'd255);
            end
            3: begin
               csr_put(grt_pkg::CSR_TRIG_LEVEL, 15'd64);
               csr_put(grt_pkg::CSR_LEFT_DEADZONE, 15'd7849);
               csr_put(grt_pkg::CSR_RIGHT_DEADZONE, 15'd8689);
               csr_put(grt_pkg::CSR_HB_PERIOD, 15'd0);
            end
            4: begin
               csr_put(grt_pkg::CSR_TRIG_LEVEL, 15'd1);
               csr_put(grt_pkg::CSR_LEFT_DEADZONE, 15'd32766);
               csr_put(grt_pkg::CSR_RIGHT_DEADZONE, 15'd1);
               csr_put(grt_pkg::CSR_HB_PERIOD, 15'd2);
            end
            default: begin
               // upper data bits must be dropped by the 8-bit registers
               csr_put(grt_pkg::CSR_TRIG_LEVEL, {7'($urandom), 8'($urandom)});
               csr_put(grt_pkg::CSR_LEFT_DEADZONE, 15'($urandom_range(0, 32766)));
               csr_put(grt_pkg::CSR_RIGHT_DEADZONE, 15'($urandom_range(0, 32766)));
               csr_put(grt_pkg::CSR_HB_PERIOD, {7'($urandom), 8'($urandom_range(1, 8))});
            end
         endcase
         mode = (phase - 1) / 2;
         send_idle = (mode == 0) ? 10 : (mode == 1) ? 72 : 0;
         recv_idle = (mode == 0) ? 72 : (mode == 1) ? 10 : 0;
         repeat (100) begin
            s = random_poll();
            last_poll = s;
            push_poll(s, 1'b0, none);
         end
         drain_reports();
      end

      $display("covered %0d polls and %0d reports (%0d heartbeats) over 7 register settings",
               sent_count, report_count, heartbeat_count);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
